// ===== sv/rrqs_pkg.sv =====
// Package for the quantum scheduler: queue sizing, action codes and the
// structs passed between the queue and the scheduling core. No dependencies.
`timescale 1ns / 1ps

package rrqs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] DEFAULT_QUANTUM = 16'd3;
    localparam logic [31:0] CLOCK_MAX       = 32'hFFFF_FFFF;
    localparam logic [39:0] TOTAL_MAX       = 40'hFF_FFFF_FFFF;

    localparam logic ACT_CREATE   = 1'b0;
    localparam logic ACT_DISPATCH = 1'b1;

    // one ready-queue entry
    typedef struct packed {
        logic [15:0] id;
        logic [15:0] burst;
        logic [15:0] rem;
    } t_task;

    // core -> queue
    typedef struct packed {
        logic  pop;
        logic  push;
        t_task wdata;
    } t_qctl;

    // queue -> core
    typedef struct packed {
        logic [CNT_W-1:0] count;
        t_task            head;
    } t_qstat;

endpackage

// ===== sv/rrqs_queue.sv =====
// Ready queue: register-file FIFO with head/tail pointers and fill count.
// Depends on rrqs_pkg.
`timescale 1ns / 1ps

module rrqs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rrqs_pkg::t_qctl i_ctl,
    output rrqs_pkg::t_qstat o_stat
);

    localparam logic [rrqs_pkg::PTR_W-1:0] LAST_PTR =
        rrqs_pkg::PTR_W'(rrqs_pkg::QUEUE_DEPTH - 1);
    localparam logic [rrqs_pkg::CNT_W-1:0] FULL_CNT =
        rrqs_pkg::CNT_W'(rrqs_pkg::QUEUE_DEPTH);

    rrqs_pkg::t_task r_mem [rrqs_pkg::QUEUE_DEPTH];

    logic [rrqs_pkg::PTR_W-1:0] r_head, n_head;
    logic [rrqs_pkg::PTR_W-1:0] r_tail, n_tail;
    logic [rrqs_pkg::CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count + rrqs_pkg::CNT_W'(i_ctl.push) - rrqs_pkg::CNT_W'(i_ctl.pop);
        if (i_ctl.pop) begin
            n_head = (r_head == LAST_PTR) ? '0 : r_head + rrqs_pkg::PTR_W'(1);
        end
        if (i_ctl.push) begin
            n_tail = (r_tail == LAST_PTR) ? '0 : r_tail + rrqs_pkg::PTR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // storage has no reset; only written slots are ever read
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_tail] <= i_ctl.wdata;
        end
    end

    assign o_stat.count = r_count;
    assign o_stat.head  = r_mem[r_head];

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count above depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.push && !i_ctl.pop) |-> (r_count != FULL_CNT))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.pop |-> (r_count != '0))
        else $error("pop from empty queue");
`endif

endmodule

// ===== sv/rrqs_core.sv =====
// Scheduling core: one create or dispatch per advance, saturating clock and
// totals, registered result. Depends on rrqs_pkg.
`timescale 1ns / 1ps

module rrqs_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_action,
    input  logic [15:0]      i_task_id,
    input  logic [15:0]      i_burst_time,
    input  logic [15:0]      i_quantum,
    input  rrqs_pkg::t_qstat i_qstat,
    output rrqs_pkg::t_qctl  o_qctl,
    output logic [15:0]      o_served_id,
    output logic [15:0]      o_slice_length,
    output logic [15:0]      o_remaining_after,
    output logic             o_finished,
    output logic             o_idle,
    output logic             o_dropped,
    output logic [31:0]      o_time_now,
    output logic [39:0]      o_turnaround_total,
    output logic [39:0]      o_waiting_total,
    output logic [4:0]       o_queued_count
);

    localparam logic [rrqs_pkg::CNT_W-1:0] FULL_CNT =
        rrqs_pkg::CNT_W'(rrqs_pkg::QUEUE_DEPTH);

    // state
    logic [31:0] r_clock, n_clock;
    logic [39:0] r_ta,    n_ta;
    logic [39:0] r_wt,    n_wt;

    // result register
    logic [15:0] r_served, n_served;
    logic [15:0] r_slice,  n_slice;
    logic [15:0] r_rem,    n_rem;
    logic        r_fin,    n_fin;
    logic        r_idle,   n_idle;
    logic        r_drop,   n_drop;
    logic [4:0]  r_qcnt,   n_qcnt;

    logic        full, empty;
    logic [15:0] slice, rem_new;
    logic [32:0] clk_sum;
    logic [31:0] clk_new, wait_val;
    logic [40:0] ta_sum, wt_sum;
    rrqs_pkg::t_qctl ctl;
    logic [rrqs_pkg::CNT_W-1:0] cnt_after;

    always_comb begin
        full     = (i_qstat.count == FULL_CNT);
        empty    = (i_qstat.count == '0);
        slice    = (i_qstat.head.rem < i_quantum) ? i_qstat.head.rem : i_quantum;
        rem_new  = i_qstat.head.rem - slice;
        clk_sum  = {1'b0, r_clock} + 33'(slice);
        clk_new  = clk_sum[32] ? rrqs_pkg::CLOCK_MAX : clk_sum[31:0];
        wait_val = (clk_new > 32'(i_qstat.head.burst)) ?
                   clk_new - 32'(i_qstat.head.burst) : 32'd0;
        ta_sum   = {1'b0, r_ta} + 41'(clk_new);
        wt_sum   = {1'b0, r_wt} + 41'(wait_val);

        ctl       = '0;
        n_clock   = r_clock;
        n_ta      = r_ta;
        n_wt      = r_wt;
        n_served  = '0;
        n_slice   = '0;
        n_rem     = '0;
        n_fin     = 1'b0;
        n_idle    = 1'b0;
        n_drop    = 1'b0;

        case (i_action)
            rrqs_pkg::ACT_CREATE: begin
                if (full) begin
                    n_drop = 1'b1;
                end else begin
                    ctl.push  = 1'b1;
                    ctl.wdata = '{id: i_task_id, burst: i_burst_time, rem: i_burst_time};
                end
            end
            rrqs_pkg::ACT_DISPATCH: begin
                if (empty) begin
                    n_idle = 1'b1;
                end else begin
                    ctl.pop  = 1'b1;
                    n_clock  = clk_new;
                    n_served = i_qstat.head.id;
                    n_slice  = slice;
                    n_rem    = rem_new;
                    if (rem_new == '0) begin
                        n_fin = 1'b1;
                        n_ta  = (ta_sum >= 41'(rrqs_pkg::TOTAL_MAX)) ?
                                rrqs_pkg::TOTAL_MAX : ta_sum[39:0];
                        n_wt  = (wt_sum >= 41'(rrqs_pkg::TOTAL_MAX)) ?
                                rrqs_pkg::TOTAL_MAX : wt_sum[39:0];
                    end else begin
                        ctl.push  = 1'b1;
                        ctl.wdata = '{id: i_qstat.head.id, burst: i_qstat.head.burst,
                                      rem: rem_new};
                    end
                end
            end
            default: begin
                n_idle = 1'b0;
            end
        endcase

        cnt_after = i_qstat.count + rrqs_pkg::CNT_W'(ctl.push)
                    - rrqs_pkg::CNT_W'(ctl.pop);
        n_qcnt    = 5'(cnt_after);

        // queue only moves when the item actually advances
        o_qctl      = ctl;
        o_qctl.pop  = ctl.pop  & i_adv;
        o_qctl.push = ctl.push & i_adv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock <= '0;
            r_ta    <= '0;
            r_wt    <= '0;
        end else if (i_adv) begin
            r_clock <= n_clock;
            r_ta    <= n_ta;
            r_wt    <= n_wt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_served <= n_served;
            r_slice  <= n_slice;
            r_rem    <= n_rem;
            r_fin    <= n_fin;
            r_idle   <= n_idle;
            r_drop   <= n_drop;
            r_qcnt   <= n_qcnt;
        end
    end

    assign o_served_id        = r_served;
    assign o_slice_length     = r_slice;
    assign o_remaining_after  = r_rem;
    assign o_finished         = r_fin;
    assign o_idle             = r_idle;
    assign o_dropped          = r_drop;
    assign o_time_now         = r_clock;
    assign o_turnaround_total = r_ta;
    assign o_waiting_total    = r_wt;
    assign o_queued_count     = r_qcnt;

endmodule

// ===== sv/round_robin_quantum_scheduler.sv =====
// Top level of the quantum scheduler: input register, handshake, quantum
// register. Depends on rrqs_pkg, rrqs_queue and rrqs_core.
`timescale 1ns / 1ps

// Usage
//   Input channel (i_in_valid / o_in_ready): one beat is one item, either a
//   create (task id + burst time, appended to the ready queue) or a dispatch
//   (pop the head task, run one slice, re-queue it or retire it).
//   Output channel (o_out_valid / i_out_ready): exactly one result beat per
//   input beat, in order.
//   Config: i_cfg_we writes i_cfg_data into the quantum at the clock edge;
//   write only while the block is idle.
// Timing
//   An accepted beat lands in the input register; on the next edge where the
//   result register is free it is processed and the result is registered.
//   Throughput is one beat per cycle while i_out_ready is high: the queue
//   is a register file read at the head pointer, so pop and re-queue both
//   take effect on the same clock edge.
// Reset (synchronous, active low)
//   Empties the queue, zeroes clock and totals, sets quantum to 3; no
//   clearing pass is needed.
// Backpressure
//   While i_out_ready is low the result holds; one more beat can still be
//   taken into the input register, after which o_in_ready drops.

module round_robin_quantum_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [15:0] i_task_id,
    input  logic [15:0] i_burst_time,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_served_id,
    output logic [15:0] o_slice_length,
    output logic [15:0] o_remaining_after,
    output logic        o_finished,
    output logic        o_idle,
    output logic        o_dropped,
    output logic [31:0] o_time_now,
    output logic [39:0] o_turnaround_total,
    output logic [39:0] o_waiting_total,
    output logic [4:0]  o_queued_count
);

    logic        r_in_vld, n_in_vld;
    logic        r_out_vld, n_out_vld;
    logic        r_act;
    logic [15:0] r_id;
    logic [15:0] r_burst;
    logic [15:0] r_quantum;
    logic        adv;
    logic        in_beat;

    rrqs_pkg::t_qctl  qctl;
    rrqs_pkg::t_qstat qstat;

    // advance when an item is staged and the result slot is free or draining
    assign adv        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || adv;
    assign in_beat    = i_in_valid && o_in_ready;

    always_comb begin
        n_in_vld  = in_beat ? 1'b1 : (adv ? 1'b0 : r_in_vld);
        n_out_vld = adv ? 1'b1 : (i_out_ready ? 1'b0 : r_out_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_quantum <= rrqs_pkg::DEFAULT_QUANTUM;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                r_quantum <= i_cfg_data;
            end
        end
    end

    // input payload register
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_act   <= i_action;
            r_id    <= i_task_id;
            r_burst <= i_burst_time;
        end
    end

    rrqs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (qctl),
        .o_stat  (qstat)
    );

    rrqs_core u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_adv              (adv),
        .i_action           (r_act),
        .i_task_id          (r_id),
        .i_burst_time       (r_burst),
        .i_quantum          (r_quantum),
        .i_qstat            (qstat),
        .o_qctl             (qctl),
        .o_served_id        (o_served_id),
        .o_slice_length     (o_slice_length),
        .o_remaining_after  (o_remaining_after),
        .o_finished         (o_finished),
        .o_idle             (o_idle),
        .o_dropped          (o_dropped),
        .o_time_now         (o_time_now),
        .o_turnaround_total (o_turnaround_total),
        .o_waiting_total    (o_waiting_total),
        .o_queued_count     (o_queued_count)
    );

    assign o_out_valid = r_out_vld;

`ifndef ASSERT_OFF
    a_adv_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> o_out_valid)
        else $error("processed item produced no result");
    a_queue_idle_no_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |-> (!qctl.pop && !qctl.push))
        else $error("queue moved without an item advancing");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result beat dropped before it was taken");
`endif

endmodule
